// ===== hdl/fixed_block_pool_allocator_unit_macros.svh =====
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fbpa_pkg.sv =====
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int STEP_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 32;
    localparam int BS_W    = 17;
    localparam int CNT_W   = 9;
    localparam int PROD_W  = BS_W + CNT_W;
    localparam int REM_W   = BS_W + IDX_W;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REALLOC = 2'd2,
        REQ_RESET   = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ZERO_SIZE   = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_EXHAUSTED   = 3'd3,
        ST_NULL_IGNORED = 3'd4,
        ST_FOREIGN     = 3'd5,
        ST_UNDERFLOW   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_OWN,
        ACT_ALLOC_HEAD,
        ACT_ALLOC_WM,
        ACT_FREE,
        ACT_RESET,
        ACT_KEEP
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_RANGE,
        S_DIV,
        S_DECIDE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic              load;
        logic              check;
        logic              mul;
        logic              range_chk;
        logic              div_step;
        logic              decide;
        logic              finish;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic early_done;
        logic need_own;
        logic foreign;
        logic out_ready;
    } sts_t;

endpackage

// ===== hdl/fbpa_ram.sv =====
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fbpa_ctrl.sv =====
module fbpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  fbpa_pkg::sts_t sts,
    output fbpa_pkg::cmd_t cmd
);
    import fbpa_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.early_done ? S_FINISH : S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = sts.need_own ? S_RANGE : S_FINISH;
            end
            S_RANGE:
            begin
                cmd.range_chk = 1'b1;
                step_next     = STEP_W'(IDX_W - 1);
                state_next    = sts.foreign ? S_FINISH : S_DIV;
            end
            S_DIV:
            begin
                // one quotient bit per cycle, most significant first
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register can take the result
                cmd.finish = sts.out_ready;
                if (sts.out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fbpa_dp.sv =====
`include "fixed_block_pool_allocator_unit_macros.svh"

module fbpa_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]         cfg_data,
    input  logic [1:0]                         req_type,
    input  logic [fbpa_pkg::SIZE_W-1:0]        req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]        addr_in,
    input  fbpa_pkg::cmd_t                     cmd,
    output fbpa_pkg::sts_t                     sts,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [fbpa_pkg::ADDR_W-1:0]        addr_out,
    output logic [2:0]                         status,
    output logic [fbpa_pkg::CNT_W-1:0]         used_count,
    output logic [fbpa_pkg::CNT_W-1:0]         free_count
);
    import fbpa_pkg::*;

    // configuration
    logic [ADDR_W-1:0] base_addr_reg;
    logic [BS_W-1:0]   blk_bytes_reg;
    logic [CNT_W-1:0]  block_count_reg;
    logic [CNT_W-1:0]  eff_count;

    // pool state
    logic [IDX_W-1:0]  free_head_reg, free_head_next;
    logic              head_valid_reg, head_valid_next;
    logic [CNT_W-1:0]  watermark_reg, watermark_next;
    logic [CNT_W-1:0]  used_blocks_reg, used_blocks_next;

    // request and work registers
    req_type_t         req_type_reg;
    logic [SIZE_W-1:0] req_size_reg;
    logic [ADDR_W-1:0] addr_in_reg;
    act_t              act_reg;
    status_t           res_status_reg;
    logic [CNT_W-1:0]  mul_b_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ADDR_W:0]   diff_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  quo_reg;

    // output register
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    status_t           out_status_reg;
    logic [CNT_W-1:0]  out_used_reg;
    logic [CNT_W-1:0]  out_free_reg;

    logic              is_alloc;
    logic              size_zero;
    logic              size_big;
    act_t              chk_act;
    status_t           chk_status;
    logic              chk_done;
    logic [CNT_W-1:0]  chk_mul_b;
    logic              foreign;
    logic [REM_W-1:0]  trial;
    logic [ADDR_W-1:0] res_addr;
    logic [IDX_W-1:0]  ram_rdata;
    logic              ram_we;

    assign eff_count = (block_count_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                              : block_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg   <= ADDR_W'(4096);
            blk_bytes_reg   <= BS_W'(16);
            block_count_reg <= CNT_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_ADDR:   base_addr_reg   <= cfg_data[ADDR_W-1:0];
                CFG_BLK_BYTES:   blk_bytes_reg   <= cfg_data[BS_W-1:0];
                CFG_BLOCK_COUNT: block_count_reg <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign is_alloc  = (req_type_reg == REQ_ALLOC) ||
                       ((req_type_reg == REQ_REALLOC) && (addr_in_reg == '0));
    assign size_zero = (req_size_reg == '0);
    assign size_big  = (req_size_reg > SIZE_W'(blk_bytes_reg));

    // first look at the request: settle what needs no arithmetic
    always_comb
    begin
        chk_act    = ACT_NONE;
        chk_status = ST_OK;
        chk_done   = 1'b1;
        chk_mul_b  = eff_count;
        if (req_type_reg == REQ_RESET)
        begin
            chk_act = ACT_RESET;
        end
        else if (is_alloc)
        begin
            if (size_zero)
            begin
                chk_status = ST_ZERO_SIZE;
            end
            else if (size_big)
            begin
                chk_status = ST_TOO_LARGE;
            end
            else if (head_valid_reg)
            begin
                chk_act   = ACT_ALLOC_HEAD;
                chk_mul_b = CNT_W'(free_head_reg);
                chk_done  = 1'b0;
            end
            else if (watermark_reg < eff_count)
            begin
                chk_act   = ACT_ALLOC_WM;
                chk_mul_b = watermark_reg;
                chk_done  = 1'b0;
            end
            else
            begin
                chk_status = ST_EXHAUSTED;
            end
        end
        else if (addr_in_reg == '0)
        begin
            chk_status = ST_NULL_IGNORED;
        end
        else
        begin
            chk_act  = ACT_OWN;
            chk_done = 1'b0;
        end
    end

    assign foreign = (blk_bytes_reg == '0) || diff_reg[ADDR_W] ||
                     (diff_reg[ADDR_W-1:0] >= ADDR_W'(prod_reg));
    assign trial   = REM_W'(blk_bytes_reg) << cmd.step;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req_type_t'(req_type);
            req_size_reg <= req_size;
            addr_in_reg  <= addr_in;
        end
        if (cmd.check)
        begin
            act_reg        <= chk_act;
            res_status_reg <= chk_status;
            mul_b_reg      <= chk_mul_b;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(blk_bytes_reg) * PROD_W'(mul_b_reg);
            diff_reg <= {1'b0, addr_in_reg} - {1'b0, base_addr_reg};
        end
        if (cmd.range_chk)
        begin
            rem_reg <= diff_reg[REM_W-1:0];
            quo_reg <= '0;
            if (foreign)
            begin
                act_reg        <= ACT_NONE;
                res_status_reg <= ST_FOREIGN;
            end
        end
        if (cmd.div_step && (rem_reg >= trial))
        begin
            rem_reg           <= rem_reg - trial;
            quo_reg[cmd.step] <= 1'b1;
        end
        if (cmd.decide)
        begin
            if (rem_reg != '0)
            begin
                act_reg        <= ACT_NONE;
                res_status_reg <= ST_FOREIGN;
            end
            else if (req_type_reg == REQ_FREE)
            begin
                if (used_blocks_reg == '0)
                begin
                    act_reg        <= ACT_NONE;
                    res_status_reg <= ST_UNDERFLOW;
                end
                else
                begin
                    act_reg        <= ACT_FREE;
                    res_status_reg <= ST_OK;
                end
            end
            else if (size_zero)
            begin
                act_reg        <= ACT_NONE;
                res_status_reg <= ST_ZERO_SIZE;
            end
            else if (size_big)
            begin
                act_reg        <= ACT_NONE;
                res_status_reg <= ST_TOO_LARGE;
            end
            else
            begin
                act_reg        <= ACT_KEEP;
                res_status_reg <= ST_OK;
            end
        end
    end

    // commit the request to the pool state
    always_comb
    begin
        free_head_next   = free_head_reg;
        watermark_next   = watermark_reg;
        used_blocks_next = used_blocks_reg;
        res_addr         = '0;
        ram_we           = 1'b0;
        case (act_reg)
            ACT_ALLOC_HEAD:
            begin
                free_head_next   = ram_rdata;
                used_blocks_next = used_blocks_reg + 1'b1;
                res_addr         = base_addr_reg + ADDR_W'(prod_reg);
            end
            ACT_ALLOC_WM:
            begin
                watermark_next   = watermark_reg + 1'b1;
                used_blocks_next = used_blocks_reg + 1'b1;
                res_addr         = base_addr_reg + ADDR_W'(prod_reg);
            end
            ACT_FREE:
            begin
                ram_we           = cmd.finish;
                free_head_next   = quo_reg;
                used_blocks_next = used_blocks_reg - 1'b1;
            end
            ACT_RESET:
            begin
                free_head_next   = '0;
                watermark_next   = '0;
                used_blocks_next = '0;
            end
            ACT_KEEP:
            begin
                res_addr = addr_in_reg;
            end
            default:
            begin
                res_addr = '0;
            end
        endcase
        head_valid_next = (watermark_next > used_blocks_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg   <= '0;
            head_valid_reg  <= 1'b0;
            watermark_reg   <= '0;
            used_blocks_reg <= '0;
        end
        else if (cmd.finish)
        begin
            free_head_reg   <= free_head_next;
            head_valid_reg  <= head_valid_next;
            watermark_reg   <= watermark_next;
            used_blocks_reg <= used_blocks_next;
        end
    end

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_next_index (
        .clk   (clk),
        .we    (ram_we),
        .waddr (quo_reg),
        .wdata (free_head_reg),
        .re    (cmd.check),
        .raddr (free_head_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_addr_reg   <= res_addr;
            out_status_reg <= res_status_reg;
            out_used_reg   <= used_blocks_next;
            out_free_reg   <= (eff_count > used_blocks_next) ?
                              (eff_count - used_blocks_next) : '0;
        end
    end

    assign sts.early_done = chk_done;
    assign sts.need_own   = (act_reg == ACT_OWN);
    assign sts.foreign    = foreign;
    assign sts.out_ready  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign addr_out   = out_addr_reg;
    assign status     = out_status_reg;
    assign used_count = out_used_reg;
    assign free_count = out_free_reg;

    `FBPA_ASSERT_NOW(a_used_within_wm, 1'b1, used_blocks_reg <= watermark_reg,
                     "used count above watermark")
    `FBPA_ASSERT_NOW(a_head_tracks_list, 1'b1,
                     head_valid_reg == (watermark_reg > used_blocks_reg),
                     "head_valid out of step with free list")
    `FBPA_ASSERT_NOW(a_fail_gives_null, out_valid_reg && (out_status_reg != ST_OK),
                     out_addr_reg == '0, "failed request returned an address")
    `FBPA_ASSERT_NEXT(a_free_drops_used, cmd.finish && (act_reg == ACT_FREE),
                      used_blocks_reg == $past(used_blocks_reg) - 1'b1,
                      "free did not release a block")

endmodule

// ===== hdl/fixed_block_pool_allocator_unit.sv =====
// Fixed-size block pool allocator. Equal blocks start at base_addr; freed blocks go on a
// LIFO list held in a 256 x 8 next-index RAM, and blocks never handed out are taken in
// address order by a watermark, so a pool reset takes effect at once with no clearing
// pass. One request is in flight at a time and in_stall is high from acceptance until its
// result is loaded into the output register. A pool reset, a null free and an alloc
// rejected on size or exhaustion go from the first check straight to the result; a
// successful alloc adds the index-times-size multiply. Free and realloc with an address
// use the same multiplier for a range check, then a restoring divider turns the offset
// into an 8-bit block index (log2 of the 256-block maximum), one quotient bit per cycle.
// An address out of range is rejected after the range check, with no divide. A result
// waiting under out_stall holds the next request in its finish step and so holds back
// the next acceptance. Configuration registers take effect on the next request; the user
// must write them only while no request is in flight, as the block does not enforce it.
module fixed_block_pool_allocator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     req_type,
    input  logic [fbpa_pkg::SIZE_W-1:0]    req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]    addr_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fbpa_pkg::ADDR_W-1:0]    addr_out,
    output logic [2:0]                     status,
    output logic [fbpa_pkg::CNT_W-1:0]     used_count,
    output logic [fbpa_pkg::CNT_W-1:0]     free_count
);
    import fbpa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fbpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    fbpa_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .req_size   (req_size),
        .addr_in    (addr_in),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .addr_out   (addr_out),
        .status     (status),
        .used_count (used_count),
        .free_count (free_count)
    );

endmodule
